[src/sti_pkg.sv]
// ----------------------------------------------------------------------------
// sti_pkg
// Shared types and constants for the sorted key table: default sizes,
// field widths, command and status codes, and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package sti_pkg;

   localparam int DEPTH_DEFAULT    = 16;
   localparam int KEY_BITS_DEFAULT = 64;

   localparam int IN_KEY_BITS  = 64;
   localparam int NAME_BITS    = 64;
   localparam int QTY_BITS     = 32;
   localparam int STATUS_BITS  = 3;
   localparam int POS_BITS     = 5;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_DELETE = 1'b1;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_INSERTED  = 3'd0,
      ST_MERGED    = 3'd1,
      ST_DELETED   = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_COMPARE,
      S_DECIDE,
      S_SHIFT_UP,
      S_SHIFT_DOWN
   } state_type;

endpackage : sti_pkg

`default_nettype wire

[src/sorted_table_insert_delete.sv]
// ----------------------------------------------------------------------------
// sorted_table_insert_delete
// Table of up to DEPTH entries kept in ascending key order. Insert merges
// into a matching key or opens a slot unless full; delete closes the gap.
// ----------------------------------------------------------------------------
// Sequence: S binary search steps (S <= ceil(log2(count+1))), each a read in
//   S_SEARCH and a compare in S_COMPARE, then a lower-bound read and S_DECIDE,
//   which ends merge, full and not found; insert and delete then move M entries
//   in S_SHIFT_UP or S_SHIFT_DOWN, one move per cycle, before they end.
// One transaction at a time; busy falls in the rsp_strobe cycle, start taken.
// Reset empties the table (count to zero); memory is not cleared; no stalls.
`default_nettype none

module sorted_table_insert_delete #(
   parameter int DEPTH    = sti_pkg::DEPTH_DEFAULT,
   parameter int KEY_BITS = sti_pkg::KEY_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic                                 req_command,
   input  wire logic        [sti_pkg::IN_KEY_BITS-1:0] req_entry_key,
   input  wire logic        [sti_pkg::NAME_BITS-1:0] req_entry_name,
   input  wire logic signed [sti_pkg::QTY_BITS-1:0]  req_entry_quantity,
   output logic                                      rsp_strobe,
   output logic             [sti_pkg::STATUS_BITS-1:0] rsp_status,
   output logic             [sti_pkg::POS_BITS-1:0]  rsp_position,
   output logic             [sti_pkg::POS_BITS-1:0]  rsp_entry_count,
   output logic signed      [sti_pkg::QTY_BITS-1:0]  rsp_stored_quantity
);
   import sti_pkg::*;

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

   state_type state_ff, state_in;

   logic                       cmd_ff, cmd_in;
   logic [KEY_BITS-1:0]        key_ff, key_in;
   logic [NAME_BITS-1:0]       name_ff, name_in;
   logic signed [QTY_BITS-1:0] qty_ff, qty_in;
   logic [CNT_W-1:0]           lo_ff, lo_in;
   logic [CNT_W-1:0]           hi_ff, hi_in;
   logic [CNT_W-1:0]           mid_ff, mid_in;
   logic [CNT_W-1:0]           ptr_ff, ptr_in;
   logic [ADDR_W-1:0]          wdst_ff, wdst_in;
   logic                       pend_ff, pend_in;
   logic [CNT_W-1:0]           count_ff, count_in;

   logic                       rsp_strobe_ff, rsp_strobe_in;
   status_type                 rsp_status_ff, rsp_status_in;
   logic [POS_BITS-1:0]        rsp_position_ff, rsp_position_in;
   logic [POS_BITS-1:0]        rsp_count_ff, rsp_count_in;
   logic signed [QTY_BITS-1:0] rsp_qty_ff, rsp_qty_in;

   logic                       wr_en, rd_en;
   logic [ADDR_W-1:0]          wr_addr, rd_addr;
   logic [KEY_BITS-1:0]        wr_key, rd_key;
   logic [NAME_BITS-1:0]       wr_name, rd_name;
   logic [QTY_BITS-1:0]        wr_qty, rd_qty;

   logic                       key_le, key_eq;
   logic signed [QTY_BITS-1:0] qty_sum;

   logic [CNT_W-1:0]           mid_calc;
   logic                       search_open, lo_in_table, hit, finish;
   logic [CNT_W+POS_BITS-1:0]  pos_wide, count_wide;

   sti_store #(
      .DEPTH    (DEPTH),
      .KEY_BITS (KEY_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_key  (wr_key),
      .wr_name (wr_name),
      .wr_qty  (wr_qty),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_key  (rd_key),
      .rd_name (rd_name),
      .rd_qty  (rd_qty)
   );

   sti_alu #(
      .KEY_BITS (KEY_BITS)
   ) u_alu (
      .key_a   (key_ff),
      .key_b   (rd_key),
      .qty_a   (signed'(rd_qty)),
      .qty_b   (qty_ff),
      .key_le  (key_le),
      .key_eq  (key_eq),
      .qty_sum (qty_sum)
   );

   assign search_open = (lo_ff < hi_ff);
   assign mid_calc    = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign lo_in_table = (lo_ff < count_ff);
   assign hit         = lo_in_table && key_eq;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_SEARCH;
         end
         S_SEARCH: begin
            state_in = search_open ? S_COMPARE : S_DECIDE;
         end
         S_COMPARE: begin
            state_in = S_SEARCH;
         end
         S_DECIDE: begin
            if (cmd_ff == CMD_INSERT) begin
               if (!hit && (count_ff < DEPTH_CNT)) state_in = S_SHIFT_UP;
               else                                state_in = S_IDLE;
            end else begin
               state_in = hit ? S_SHIFT_DOWN : S_IDLE;
            end
         end
         S_SHIFT_UP: begin
            if (!(ptr_ff > lo_ff) && !pend_ff) state_in = S_IDLE;
         end
         S_SHIFT_DOWN: begin
            if (!(ptr_ff < count_ff) && !pend_ff) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath, memory control and result
   always_comb begin
      cmd_in   = cmd_ff;
      key_in   = key_ff;
      name_in  = name_ff;
      qty_in   = qty_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      ptr_in   = ptr_ff;
      wdst_in  = wdst_ff;
      pend_in  = pend_ff;
      count_in = count_ff;

      rd_en    = 1'b0;
      rd_addr  = lo_ff[ADDR_W-1:0];
      wr_en    = 1'b0;
      wr_addr  = wdst_ff;
      wr_key   = rd_key;
      wr_name  = rd_name;
      wr_qty   = rd_qty;

      finish        = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_qty_in    = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in  = req_command;
               key_in  = req_entry_key[KEY_BITS-1:0];
               name_in = req_entry_name;
               qty_in  = req_entry_quantity;
               lo_in   = '0;
               hi_in   = count_ff;
            end
         end
         S_SEARCH: begin
            if (search_open) begin
               rd_en   = 1'b1;
               rd_addr = mid_calc[ADDR_W-1:0];
               mid_in  = mid_calc;
            end else begin
               // fetch the lower-bound entry for the hit check
               rd_en = lo_in_table;
            end
         end
         S_COMPARE: begin
            if (key_le) hi_in = mid_ff;
            else        lo_in = mid_ff + ONE_CNT;
         end
         S_DECIDE: begin
            pend_in = 1'b0;
            if (cmd_ff == CMD_INSERT) begin
               if (hit) begin
                  wr_en         = 1'b1;
                  wr_addr       = lo_ff[ADDR_W-1:0];
                  wr_qty        = qty_sum;
                  finish        = 1'b1;
                  rsp_status_in = ST_MERGED;
                  rsp_qty_in    = qty_sum;
               end else if (!(count_ff < DEPTH_CNT)) begin
                  finish        = 1'b1;
                  rsp_status_in = ST_FULL;
               end else begin
                  ptr_in = count_ff;
               end
            end else begin
               if (hit) begin
                  ptr_in = lo_ff + ONE_CNT;
               end else begin
                  finish        = 1'b1;
                  rsp_status_in = ST_NOT_FOUND;
               end
            end
         end
         S_SHIFT_UP: begin
            if (pend_ff) wr_en = 1'b1;
            if (ptr_ff > lo_ff) begin
               rd_en   = 1'b1;
               rd_addr = ADDR_W'(ptr_ff - ONE_CNT);
               wdst_in = ptr_ff[ADDR_W-1:0];
               ptr_in  = ptr_ff - ONE_CNT;
               pend_in = 1'b1;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               // slot is open: drop the new entry in
               wr_en         = 1'b1;
               wr_addr       = lo_ff[ADDR_W-1:0];
               wr_key        = key_ff;
               wr_name       = name_ff;
               wr_qty        = qty_ff;
               count_in      = count_ff + ONE_CNT;
               finish        = 1'b1;
               rsp_status_in = ST_INSERTED;
               rsp_qty_in    = qty_ff;
            end
         end
         S_SHIFT_DOWN: begin
            if (pend_ff) wr_en = 1'b1;
            if (ptr_ff < count_ff) begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff[ADDR_W-1:0];
               wdst_in = ADDR_W'(ptr_ff - ONE_CNT);
               ptr_in  = ptr_ff + ONE_CNT;
               pend_in = 1'b1;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               count_in      = count_ff - ONE_CNT;
               finish        = 1'b1;
               rsp_status_in = ST_DELETED;
            end
         end
         default: begin
         end
      endcase

      rsp_strobe_in   = finish;
      pos_wide        = {{POS_BITS{1'b0}}, lo_ff};
      count_wide      = {{POS_BITS{1'b0}}, count_in};
      rsp_position_in = finish ? pos_wide[POS_BITS-1:0] : rsp_position_ff;
      rsp_count_in    = finish ? count_wide[POS_BITS-1:0] : rsp_count_ff;
      if (!finish) rsp_qty_in = rsp_qty_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff          <= cmd_in;
      key_ff          <= key_in;
      name_ff         <= name_in;
      qty_ff          <= qty_in;
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      mid_ff          <= mid_in;
      ptr_ff          <= ptr_in;
      wdst_ff         <= wdst_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_position_ff <= rsp_position_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_qty_ff      <= rsp_qty_in;
   end

   assign busy                = (state_ff != S_IDLE);
   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_position        = rsp_position_ff;
   assign rsp_entry_count     = rsp_count_ff;
   assign rsp_stored_quantity = rsp_qty_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("entry count exceeds table depth");

   a_accept_search: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == S_SEARCH))
      else $error("accepted transaction did not start a search");

   a_search_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> (lo_ff <= hi_ff && hi_ff <= count_ff))
      else $error("binary search window out of order");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_DECIDE || state_ff == S_SHIFT_UP ||
                 state_ff == S_SHIFT_DOWN))
      else $error("table write outside an update state");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> (state_ff == S_IDLE && $past(state_ff) != S_IDLE))
      else $error("result strobe without a finished transaction");

endmodule : sorted_table_insert_delete

`default_nettype wire

[src/sti_store.sv]
// ----------------------------------------------------------------------------
// sti_store
// Entry memory: key, name tag and quantity per slot. One write port and
// one read port per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sti_store #(
   parameter int DEPTH    = sti_pkg::DEPTH_DEFAULT,
   parameter int KEY_BITS = sti_pkg::KEY_BITS_DEFAULT,
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [ADDR_W-1:0]             wr_addr,
   input  wire logic [KEY_BITS-1:0]           wr_key,
   input  wire logic [sti_pkg::NAME_BITS-1:0] wr_name,
   input  wire logic [sti_pkg::QTY_BITS-1:0]  wr_qty,
   input  wire logic                          rd_en,
   input  wire logic [ADDR_W-1:0]             rd_addr,
   output logic      [KEY_BITS-1:0]           rd_key,
   output logic      [sti_pkg::NAME_BITS-1:0] rd_name,
   output logic      [sti_pkg::QTY_BITS-1:0]  rd_qty
);
   import sti_pkg::*;

   logic [KEY_BITS-1:0]  key_mem  [DEPTH];
   logic [NAME_BITS-1:0] name_mem [DEPTH];
   logic [QTY_BITS-1:0]  qty_mem  [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]  <= wr_key;
         name_mem[wr_addr] <= wr_name;
         qty_mem[wr_addr]  <= wr_qty;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_key  <= key_mem[rd_addr];
         rd_name <= name_mem[rd_addr];
         rd_qty  <= qty_mem[rd_addr];
      end
   end

endmodule : sti_store

`default_nettype wire

[src/sti_alu.sv]
// ----------------------------------------------------------------------------
// sti_alu
// Shared arithmetic unit: unsigned key compare for the binary search and
// hit check, and saturating quantity add for a merge.
// ----------------------------------------------------------------------------
`default_nettype none

module sti_alu #(
   parameter int KEY_BITS = sti_pkg::KEY_BITS_DEFAULT
) (
   input  wire logic        [KEY_BITS-1:0]          key_a,
   input  wire logic        [KEY_BITS-1:0]          key_b,
   input  wire logic signed [sti_pkg::QTY_BITS-1:0] qty_a,
   input  wire logic signed [sti_pkg::QTY_BITS-1:0] qty_b,
   output logic                                     key_le,
   output logic                                     key_eq,
   output logic signed      [sti_pkg::QTY_BITS-1:0] qty_sum
);
   import sti_pkg::*;

   logic signed [QTY_BITS:0] sum_wide;

   assign key_le   = (key_a <= key_b);
   assign key_eq   = (key_a == key_b);
   assign sum_wide = {qty_a[QTY_BITS-1], qty_a} + {qty_b[QTY_BITS-1], qty_b};

   // clamp when the carry into the sign disagrees with the sign
   always_comb begin
      if (sum_wide[QTY_BITS] == sum_wide[QTY_BITS-1]) begin
         qty_sum = sum_wide[QTY_BITS-1:0];
      end else if (sum_wide[QTY_BITS]) begin
         qty_sum = {1'b1, {(QTY_BITS-1){1'b0}}};
      end else begin
         qty_sum = {1'b0, {(QTY_BITS-1){1'b1}}};
      end
   end

endmodule : sti_alu

`default_nettype wire
